FILE: src/tpt_pkg.sv
// tpt_pkg: shared types, codes and sizes for the tag presence table.
// No dependencies; compiled first.
package tpt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRANULARITY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MASTER = 4'd1;

  // operation kinds
  localparam logic [2:0] KIND_FIND = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_CHECK = 3'd2;
  localparam logic [2:0] KIND_SET = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  // presence states
  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_NEW = 3'd1;
  localparam logic [2:0] ST_GONE = 3'd2;
  localparam logic [2:0] ST_REPORTED = 3'd3;
  localparam logic [2:0] ST_CONFIRMED = 3'd4;
  localparam logic [2:0] ST_FADE_REP = 3'd5;
  localparam logic [2:0] ST_FADE_CONF = 3'd6;

  // result status
  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_BAD_STATE = 2'd3;

  // id masks for find
  localparam logic [31:0] TOP_BYTE = 32'hff000000;
  localparam logic [31:0] DROP_TOP = 32'h00ffffff;
  localparam logic [31:0] THIRD_BYTE = 32'h00ff0000;
  localparam logic [31:0] DROP_THIRD = 32'hff00ffff;
  localparam logic [31:0] KEEP_ALL = 32'hffffffff;

  typedef struct packed {
    logic [31:0] id;
    logic [2:0]  state;
    logic [31:0] last_time;
    logic [31:0] event_time;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic             clr;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  entry_index;
    logic        report;
    logic [31:0] report_id;
    logic [31:0] report_event_time;
    logic [2:0]  report_state;
  } result_t;

endpackage

FILE: src/tpt_in_if.sv
// tpt_in_if: input operation channel (valid/ready plus operation fields).
// Depends on nothing.
interface tpt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] tag_id;
  logic [7:0]  index;
  logic [2:0]  new_state;
  logic        update_event_time;
  logic [31:0] now_seconds;

  modport source (output valid, kind, tag_id, index, new_state, update_event_time,
                  now_seconds, input ready);
  modport sink (input valid, kind, tag_id, index, new_state, update_event_time,
                now_seconds, output ready);
endinterface

FILE: src/tpt_out_if.sv
// tpt_out_if: result channel (valid/ready plus result fields).
// Depends on nothing.
interface tpt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  entry_index;
  logic        report;
  logic [31:0] report_id;
  logic [31:0] report_event_time;
  logic [2:0]  report_state;

  modport source (output valid, status, entry_index, report, report_id,
                  report_event_time, report_state, input ready);
  modport sink (input valid, status, entry_index, report, report_id,
                report_event_time, report_state, output ready);
endinterface

FILE: src/tpt_cfg_if.sv
// tpt_cfg_if: configuration write channel (valid/ready, index, data).
// Depends on tpt_pkg for field widths.
interface tpt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tpt_pkg::CFG_IDX_W-1:0]  index;
  logic [tpt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/tpt_table.sv
// tpt_table: entry storage, one synchronous memory with a registered read,
// plus per-entry valid bits so reset empties the table at once. Uses tpt_pkg.
module tpt_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [tpt_pkg::IDX_W-1:0] rd_addr,
  output tpt_pkg::entry_t           rd_data,
  input  tpt_pkg::tbl_wr_t          wr
);
  import tpt_pkg::*;

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  entry_t                   rd_data_r;
  logic                     rd_ok_r;

  always_ff @(posedge clk) begin
    if (wr.en && !wr.clr) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= !wr.clr;
      end
      if (rd_en) begin
        rd_ok_r <= valid_r[rd_addr];
      end
    end
  end

  // an entry never written since reset (or cleared) reads as all zero
  assign rd_data = rd_ok_r ? rd_data_r : '0;

endmodule

FILE: src/tag_presence_table.sv
// tag_presence_table: top level, operation sequencer around tpt_table.
// Uses tpt_pkg, tpt_in_if, tpt_out_if, tpt_cfg_if and tpt_table.

// Tag presence table. One operation per input transaction (find, insert,
// check/age, set state, clear entry), one result transaction per operation.
// The block works on one operation at a time through a single read port on
// the entry memory: find and insert read one entry per cycle, walking from
// entry 0 until a hit or, on a miss, through the last entry; check, set
// state and clear go through read, modify and write, and result; an
// out-of-range index or unknown kind goes straight to the result.
// The result sits in an output register, so the next operation is taken while
// it waits. Reset empties the table in the same cycle (per-entry valid bits),
// no clearing pass. Configuration writes are always ready and must only be
// issued while no operation is in flight.
module tag_presence_table (
  input  logic     clk,
  input  logic     rst_n,
  tpt_in_if.sink   in_chan,
  tpt_out_if.source out_chan,
  tpt_cfg_if.sink  cfg_chan
);
  import tpt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;  // find / insert walk
  localparam logic [1:0] S_ACC  = 2'd2;  // single-entry read-modify-write
  localparam logic [1:0] S_HOLD = 2'd3;  // result waits for output register

  logic [1:0] state_r, state_nxt;

  // configuration
  logic [15:0] gran_r;
  logic        master_r;

  // operation in flight
  logic [2:0]       kind_r;
  logic [31:0]      tag_r;
  logic [31:0]      mask_r;
  logic [7:0]       idx8_r;
  logic [2:0]       nst_r;
  logic             upd_r;
  logic [31:0]      now_r;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  result_t res_r, res_nxt;
  result_t out_r;
  logic    out_valid_r;

  // table access
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  tbl_wr_t          wr;

  logic        in_acc;
  logic        in_range;
  logic        out_free;
  logic [31:0] mask_in;
  logic [31:0] age;
  logic        last_entry;

  tpt_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign in_range       = int'(in_chan.index) < TABLE_ENTRIES;
  assign out_free       = !out_valid_r || out_chan.ready;
  assign last_entry     = int'(cnt_r) == TABLE_ENTRIES - 1;
  assign age            = now_r - rd_data.last_time;

  // find mask: zero query bytes are wildcards for the top and third bytes
  always_comb begin
    mask_in = KEEP_ALL;
    if ((in_chan.tag_id & TOP_BYTE) == '0) begin
      mask_in = mask_in & DROP_TOP;
    end
    if ((in_chan.tag_id & THIRD_BYTE) == '0) begin
      mask_in = mask_in & DROP_THIRD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gran_r   <= 16'd10;
      master_r <= 1'b1;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.index)
        REG_GRANULARITY:  gran_r <= cfg_chan.data;
        REG_LOCAL_MASTER: master_r <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  // read address: scans start at entry 0, others read the indexed entry
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_r + 1'b1;
    if (state_r == S_IDLE) begin
      rd_en = in_acc;
      if (in_chan.kind == KIND_FIND || in_chan.kind == KIND_INSERT) begin
        rd_addr = '0;
      end else begin
        rd_addr = in_chan.index[IDX_W-1:0];
      end
    end else if (state_r == S_SCAN) begin
      rd_en = !last_entry;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    wr        = '0;
    wr.addr   = cnt_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          cnt_nxt = '0;
          if (in_chan.kind == KIND_FIND || in_chan.kind == KIND_INSERT) begin
            state_nxt = S_SCAN;
          end else if (in_chan.kind inside {KIND_CHECK, KIND_SET, KIND_CLEAR}) begin
            res_nxt.entry_index = in_chan.index;
            cnt_nxt = in_chan.index[IDX_W-1:0];
            if (in_range) begin
              state_nxt = S_ACC;
            end else begin
              res_nxt.status = STAT_RANGE;
              state_nxt = S_HOLD;
            end
          end else begin
            state_nxt = S_HOLD;  // unknown kind: all-zero answer
          end
        end
      end

      S_SCAN: begin
        // rd_data holds entry cnt_r
        if (kind_r == KIND_FIND && (rd_data.id & mask_r) == tag_r) begin
          res_nxt.status      = STAT_OK;
          res_nxt.entry_index = 8'(cnt_r);
          state_nxt = S_HOLD;
        end else if (kind_r == KIND_INSERT && rd_data.id == '0) begin
          wr.en = 1'b1;
          wr.data.id = tag_r;
          wr.data.state = ST_NEW;
          wr.data.last_time = now_r;
          wr.data.event_time = now_r;
          res_nxt.status      = STAT_OK;
          res_nxt.entry_index = 8'(cnt_r);
          state_nxt = S_HOLD;
        end else if (last_entry) begin
          res_nxt.status      = STAT_MISS;
          res_nxt.entry_index = '0;
          state_nxt = S_HOLD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_ACC: begin
        state_nxt = S_HOLD;
        wr.data   = rd_data;
        if (kind_r == KIND_SET) begin
          wr.en = 1'b1;
          wr.data.state = nst_r;
          wr.data.last_time = now_r;
          if (upd_r) begin
            wr.data.event_time = now_r;
          end
        end else if (kind_r == KIND_CLEAR) begin
          wr.en  = 1'b1;
          wr.clr = 1'b1;
        end else if (rd_data.id != '0 && age >= {16'd0, gran_r}) begin
          // aging step of a due entry
          case (rd_data.state)
            ST_NEW: begin
              wr.en  = 1'b1;
              wr.clr = 1'b1;
            end
            ST_GONE: begin
              res_nxt.report            = 1'b1;
              res_nxt.report_id         = rd_data.id;
              res_nxt.report_event_time = rd_data.event_time;
              res_nxt.report_state      = ST_GONE;
            end
            ST_REPORTED, ST_CONFIRMED: begin
              wr.en = 1'b1;
              wr.data.state = (rd_data.state == ST_REPORTED) ? ST_FADE_REP : ST_FADE_CONF;
              wr.data.last_time = now_r;
            end
            ST_FADE_REP, ST_FADE_CONF: begin
              wr.en  = 1'b1;
              wr.clr = master_r;
              wr.data.state = ST_GONE;
              wr.data.last_time = now_r;
              wr.data.event_time = now_r;
              res_nxt.report            = 1'b1;
              res_nxt.report_id         = rd_data.id;
              res_nxt.report_event_time = now_r;
              res_nxt.report_state      = ST_GONE;
            end
            default: begin
              res_nxt.status = STAT_BAD_STATE;
            end
          endcase
        end
      end

      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
    if (in_acc) begin
      kind_r <= in_chan.kind;
      tag_r  <= in_chan.tag_id;
      mask_r <= mask_in;
      idx8_r <= in_chan.index;
      nst_r  <= in_chan.new_state;
      upd_r  <= in_chan.update_event_time;
      now_r  <= in_chan.now_seconds;
    end
    if (state_r == S_HOLD && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.status            = out_r.status;
  assign out_chan.entry_index       = out_r.entry_index;
  assign out_chan.report            = out_r.report;
  assign out_chan.report_id         = out_r.report_id;
  assign out_chan.report_event_time = out_r.report_event_time;
  assign out_chan.report_state      = out_r.report_state;

  // single-index ops echo the index they were given
  a_echo_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (res_r.entry_index == idx8_r))
    else $error("single-index op lost its index echo");

  a_no_read_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD || state_r == S_ACC) |-> !rd_en)
    else $error("table read outside of issue or scan");

  a_hold_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("held result not moved to output");

  a_report_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.report) |-> (out_r.status == STAT_OK && out_r.report_state == ST_GONE))
    else $error("report with bad status or state");

  a_write_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> (state_r == S_HOLD))
    else $error("table written outside the decision cycle");

endmodule
